### hw/rtl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg: shared types and constants of the prime search block
// Widths, status codes and the request and response structs between the
// top level and the modular multiplier.
// ----------------------------------------------------------------------------
package gps_pkg;
	localparam int MaxBits     = 31;
	localparam int SearchLimit = 1000;
	localparam int PW          = 31;   // width of p and of residues
	localparam int QW          = 16;
	localparam int TW          = 5;
	localparam int UW          = $clog2(SearchLimit + 2);

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;

	typedef struct packed {
		logic          start;
		logic [PW-1:0] a;
		logic [PW-1:0] b;
		logic [PW-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic          done;
		logic [PW-1:0] r;
	} mm_rsp_t;
endpackage

### hw/rtl/gps_if.sv
// ----------------------------------------------------------------------------
// gps_in_if / gps_out_if: valid/ready channels of the prime search block
// Request and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface gps_in_if;
	logic                    valid;
	logic                    ready;
	logic [gps_pkg::TW-1:0]  bit_length;
	logic [gps_pkg::QW-1:0]  factor_q;
	modport source (output valid, bit_length, factor_q, input ready);
	modport sink   (input valid, bit_length, factor_q, output ready);
endinterface

interface gps_out_if;
	logic                    valid;
	logic                    ready;
	logic [gps_pkg::PW-1:0]  prime_p;
	logic [1:0]              status;
	modport source (output valid, prime_p, status, input ready);
	modport sink   (input valid, prime_p, status, output ready);
endinterface

### hw/rtl/gps_modmul.sv
// ----------------------------------------------------------------------------
// gps_modmul: bit-serial modular multiplier
// Computes a*b mod m, MSB first over b, one bit a cycle, using
// one shared add-and-reduce datapath. Inputs must satisfy a, b < m.
// ----------------------------------------------------------------------------
module gps_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  gps_pkg::mm_req_t  req,
	output gps_pkg::mm_rsp_t  rsp
);
	localparam int CW = $clog2(gps_pkg::PW + 1);

	logic [gps_pkg::PW-1:0] a_q, b_q, m_q, r_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q, done_q;
	logic [gps_pkg::PW+1:0] dbl, dbl_red, add, add_red;

	always_comb begin
		dbl     = {2'b0, r_q} << 1;
		dbl_red = (dbl >= {2'b0, m_q}) ? dbl - {2'b0, m_q} : dbl;
		add     = dbl_red + (b_q[gps_pkg::PW-1] ? {2'b0, a_q} : '0);
		add_red = (add >= {2'b0, m_q}) ? add - {2'b0, m_q} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(gps_pkg::PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= add_red[gps_pkg::PW-1:0];
			b_q <= b_q << 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = r_q;

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("modmul done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("modmul done held");
	a_res_lt_m: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < m_q)) else $error("modmul result not reduced");
endmodule

### hw/rtl/gps_divider.sv
// ----------------------------------------------------------------------------
// gps_divider: restoring divider, one quotient bit a cycle
// Computes n div d for a 31-bit n and a 31-bit d.
// ----------------------------------------------------------------------------
module gps_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [gps_pkg::PW-1:0]  numer,
	input  logic [gps_pkg::PW-1:0]  denom,
	output logic                    done,
	output logic [gps_pkg::PW-1:0]  quot
);
	localparam int CW = $clog2(gps_pkg::PW + 1);

	logic [gps_pkg::PW-1:0] n_q, d_q, q_q;
	logic [gps_pkg::PW-1:0] rem_q;
	logic [gps_pkg::PW:0]   trial;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q, done_q;

	assign trial = {rem_q, n_q[gps_pkg::PW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(gps_pkg::PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= numer;
			d_q   <= denom;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_q <= gps_pkg::PW'(trial - {1'b0, d_q});
				q_q   <= {q_q[gps_pkg::PW-2:0], 1'b1};
			end else begin
				rem_q <= trial[gps_pkg::PW-1:0];
				q_q   <= {q_q[gps_pkg::PW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

### hw/rtl/gost_prime_search.sv
// ----------------------------------------------------------------------------
// gost_prime_search: search for a prime p with a given prime factor q of p-1
// Operation: set-up and division, then per candidate two powers of up to 31
//   exponent bits, each bit a squaring (after a multiply when the bit is set)
//   on the bit-serial multiplier; up to 500 candidates. Zero q: no search.
// Throughput: one request at a time; ready only while idle.
// Reset: arst_n clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module gost_prime_search (
	input  logic        clk,
	input  logic        arst_n,
	gps_in_if.sink      in_ch,
	gps_out_if.source   out_ch
);
	localparam int PW = gps_pkg::PW;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIV   = 4'd1;
	localparam logic [3:0] S_DIVW  = 4'd2;
	localparam logic [3:0] S_CAND  = 4'd3;
	localparam logic [3:0] S_EXPQ  = 4'd4;
	localparam logic [3:0] S_EXPQW = 4'd5;
	localparam logic [3:0] S_PSTEP = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_SQR   = 4'd8;
	localparam logic [3:0] S_PEND  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]              state_q;
	logic [gps_pkg::TW-1:0]  t_q;
	logic [gps_pkg::QW-1:0]  q_q;
	logic [PW:0]             n_q;       // N (even), up to 2^30
	logic [gps_pkg::UW-1:0]  u_q;
	logic [PW-1:0]           p_q, acc_q, base_q, exp_q, e2_q;
	logic                    pass2_q;   // 0: Fermat power, 1: (p-1)/q power
	logic [PW-1:0]           res_p_q;
	logic [1:0]              res_st_q;
	logic                    out_valid_q;

	gps_pkg::mm_req_t        mm_req;
	gps_pkg::mm_rsp_t        mm_rsp;
	logic                    div_start, div_done;
	logic [PW-1:0]           div_n, div_d, div_quot;

	gps_modmul u_mm (.clk(clk), .arst_n(arst_n), .req(mm_req), .rsp(mm_rsp));
	gps_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start),
		.numer(div_n), .denom(div_d), .done(div_done), .quot(div_quot));

	// candidate arithmetic: (N+u)*q+1 and the range limit 2^t
	logic [gps_pkg::TW-1:0]  t_sat;
	logic [PW+1:0]           nu;
	logic [PW+gps_pkg::QW+1:0] cand;
	logic [PW+gps_pkg::QW+1:0] limit;
	logic [PW-1:0]           numer;

	always_comb begin
		t_sat = (in_ch.bit_length > gps_pkg::TW'(gps_pkg::MaxBits))
			? gps_pkg::TW'(gps_pkg::MaxBits) : in_ch.bit_length;
		numer = (t_q == '0) ? '0 : (PW'(1) << (t_q - 1'b1)) - PW'(1);
		nu    = {1'b0, n_q} + (PW+2)'(u_q);
		cand  = (PW+gps_pkg::QW+2)'(nu) * (PW+gps_pkg::QW+2)'(q_q)
			+ (PW+gps_pkg::QW+2)'(1);
		limit = (PW+gps_pkg::QW+2)'(1) << t_q;
	end

	assign div_n     = numer;
	assign div_d     = PW'(q_q);
	assign div_start = (state_q == S_DIV);

	assign in_ch.ready    = (state_q == S_IDLE) && !out_valid_q;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.prime_p = res_p_q;
	assign out_ch.status  = res_st_q;

	// exponent (p-1)/q is obtained for free: it is N+u
	logic done_exp;
	assign done_exp = (exp_q == '0);

	always_comb begin
		mm_req       = '0;
		mm_req.m     = p_q;
		if (state_q == S_PSTEP && !done_exp) begin
			mm_req.start = 1'b1;
			mm_req.a     = exp_q[0] ? acc_q : base_q;
			mm_req.b     = base_q;
		end else if (state_q == S_MUL && mm_rsp.done) begin
			mm_req.start = 1'b1;
			mm_req.a     = base_q;
			mm_req.b     = base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.factor_q == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV:   state_q <= S_DIVW;
				S_DIVW:  if (div_done) state_q <= S_CAND;
				S_CAND: begin
					if (u_q >= gps_pkg::UW'(gps_pkg::SearchLimit)) begin
						state_q <= S_OUT;
					end else if (cand >= limit) begin
						state_q <= S_OUT;
					end else if (cand < (PW+gps_pkg::QW+2)'(2)) begin
						state_q <= S_CAND;
					end else begin
						state_q <= S_PSTEP;
					end
				end
				S_PSTEP: begin
					if (done_exp) state_q <= S_PEND;
					else if (exp_q[0]) state_q <= S_MUL;
					else state_q <= S_SQR;
				end
				S_MUL:   if (mm_rsp.done) state_q <= S_SQR;
				S_SQR:   if (mm_rsp.done) state_q <= S_PSTEP;
				S_PEND: begin
					if (!pass2_q) begin
						state_q <= (acc_q == PW'(1)) ? S_PSTEP : S_CAND;
					end else begin
						state_q <= (acc_q != PW'(1)) ? S_OUT : S_CAND;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				// load only on a taken request; hold the waiting result otherwise
				if (in_ch.valid && in_ch.ready) begin
					t_q      <= t_sat;
					q_q      <= in_ch.factor_q;
					u_q      <= '0;
					res_p_q  <= '0;
					res_st_q <= gps_pkg::ST_EXHAUSTED;
				end
			end
			S_DIVW: begin
				if (div_done) begin
					n_q <= {1'b0, div_quot} + (PW+1)'(div_quot[0]);
				end
			end
			S_CAND: begin
				if (u_q >= gps_pkg::UW'(gps_pkg::SearchLimit)) begin
					res_st_q <= gps_pkg::ST_EXHAUSTED;
				end else if (cand >= limit) begin
					res_st_q <= gps_pkg::ST_RANGE;
				end else begin
					p_q     <= cand[PW-1:0];
					exp_q   <= cand[PW-1:0] - PW'(1);
					e2_q    <= nu[PW-1:0];
					acc_q   <= PW'(1);
					// 2 mod p: zero only for p = 2
					base_q  <= (cand[PW-1:0] == PW'(2)) ? '0 : PW'(2);
					pass2_q <= 1'b0;
					u_q     <= u_q + gps_pkg::UW'(2);
				end
			end
			S_PSTEP: ;
			S_MUL: if (mm_rsp.done) acc_q <= mm_rsp.r;
			S_SQR: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.r;
					exp_q  <= exp_q >> 1;
				end
			end
			S_PEND: begin
				if (!pass2_q) begin
					exp_q   <= e2_q;
					acc_q   <= PW'(1);
					base_q  <= PW'(2);
					pass2_q <= 1'b1;
				end else if (acc_q != PW'(1)) begin
					res_p_q  <= p_q;
					res_st_q <= gps_pkg::ST_FOUND;
				end
			end
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ch.ready) else $error("request taken while result waits");
	a_found_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_st_q == gps_pkg::ST_FOUND) |-> (res_p_q != '0))
		else $error("found status with zero prime");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_st_q != gps_pkg::ST_FOUND) |-> (res_p_q == '0))
		else $error("prime reported with failure status");
endmodule
